// File: sv/usbrx_pkg.sv
// ----------------------------------------------------------------------------
// usbrx_pkg
// Shared types and constants of the USB bulk-in frame splitter.
// ----------------------------------------------------------------------------
package usbrx_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_OVERRUN = 2'd2;
  localparam logic [1:0] KIND_FAIL    = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam int unsigned CRC_BYTES   = 4;
  localparam int unsigned MIN_FRAME   = 18;
  localparam logic [13:0] PAYLOAD_MAX = 14'd16383;
  localparam logic [13:0] MAX_PAYLOAD_RESET = 14'd1500;

  typedef struct packed {
    logic        op;
    logic [15:0] transfer_length;
    logic        transfer_ok;
    logic [7:0]  data_byte;
    logic        queue_full;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [13:0] payload_length;
  } result_t;

endpackage

// File: sv/usbrx_in_reg.sv
// ----------------------------------------------------------------------------
// usbrx_in_reg
// Input register: holds one accepted beat until the parser consumes it.
// ----------------------------------------------------------------------------
module usbrx_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  usbrx_pkg::item_t s_item,
  input  logic            advance,
  output logic            in_valid,
  output usbrx_pkg::item_t item
);

  assign s_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

// File: sv/usbrx_parser.sv
// ----------------------------------------------------------------------------
// usbrx_parser
// Framing state and the per-beat decision: command word assembly, frame
// checks, payload marking and frame stride.
// ----------------------------------------------------------------------------
module usbrx_parser #(
  parameter int PREFIX_BYTES  = 10,
  parameter int LENGTH_BITS   = 14,
  parameter int ERROR_BIT_POS = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [13:0]        cfg_data,
  input  logic               step,
  input  usbrx_pkg::item_t   item,
  output logic               res_valid,
  output usbrx_pkg::result_t res
);

  localparam logic [15:0] PREFIX16   = 16'(PREFIX_BYTES);
  localparam logic [15:0] MIN_XFER   = 16'(PREFIX_BYTES + usbrx_pkg::MIN_FRAME);
  localparam logic [31:0] LEN_MASK   = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [15:0] CRC16      = 16'(usbrx_pkg::CRC_BYTES);
  localparam logic [15:0] MIN_FRAME16 = 16'(usbrx_pkg::MIN_FRAME);

  logic [13:0] max_payload;
  logic        framing;
  logic [31:0] cw;
  logic [15:0] bl;
  logic [15:0] pos;
  logic [13:0] cfl;
  logic        acc;

  logic        head;
  logic [31:0] cw_upd;
  logic [31:0] cw_eval;
  logic [15:0] len16;
  logic [15:0] len_m4;
  logic [15:0] bl_n;
  logic [16:0] avail;
  logic [16:0] need;
  logic        err;
  logic [13:0] err_pl;
  logic [15:0] p;
  logic        emit_payload;
  logic [17:0] stride;
  logic [16:0] pos1;
  logic        end_frame;
  logic        live;

  assign head    = (pos[15:2] == 14'd0);
  assign cw_upd  = cw | ({24'd0, item.data_byte} << {pos[1:0], 3'b000});
  assign cw_eval = head ? cw_upd : cw;
  assign len16   = cw_eval[15:0] & LEN_MASK[15:0];
  assign len_m4  = len16 - CRC16;
  assign bl_n    = bl - 16'd1;
  assign avail   = {1'b0, bl_n} + 17'd4;
  assign need    = {1'b0, len16} + 17'(PREFIX_BYTES);

  assign err = cw_eval[ERROR_BIT_POS] || (need > avail) ||
               (len16 > ({2'b00, max_payload} + CRC16)) || (len16 < MIN_FRAME16);

  always_comb begin
    if (len16 < CRC16) begin
      err_pl = 14'd0;
    end else if (len_m4 > {2'b00, usbrx_pkg::PAYLOAD_MAX}) begin
      err_pl = usbrx_pkg::PAYLOAD_MAX;
    end else begin
      err_pl = len_m4[13:0];
    end
  end

  assign p            = pos - PREFIX16;
  assign emit_payload = acc && (pos >= PREFIX16) && (p < {2'b00, cfl});

  // Next frame starts after the prefix plus the length padded to a word.
  assign stride    = 18'(PREFIX_BYTES) +
                     {1'b0, (({1'b0, len16} + 17'd3) & ~17'd3)};
  assign pos1      = {1'b0, pos} + 17'd1;
  assign end_frame = (pos >= 16'd3) && ({1'b0, pos1} >= stride);
  assign live      = framing && (bl != 16'd0);

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (item.op == usbrx_pkg::OP_START) begin
      if (!item.transfer_ok) begin
        res.kind  = usbrx_pkg::KIND_FAIL;
        res_valid = 1'b1;
      end
    end else if (live) begin
      if (pos == 16'd3) begin
        if (err) begin
          res.kind           = usbrx_pkg::KIND_ERROR;
          res.payload_length = err_pl;
          res_valid          = 1'b1;
        end else if (item.queue_full) begin
          res.kind           = usbrx_pkg::KIND_OVERRUN;
          res.payload_length = len_m4[13:0];
          res_valid          = 1'b1;
        end
      end else if (!head && emit_payload) begin
        res.kind           = usbrx_pkg::KIND_PAYLOAD;
        res.payload_byte   = item.data_byte;
        res.first_of_frame = (p == 16'd0);
        res.last_of_frame  = ((p + 16'd1) == {2'b00, cfl});
        res.payload_length = cfl;
        res_valid          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= usbrx_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      framing <= 1'b0;
      cw      <= '0;
      bl      <= '0;
      pos     <= '0;
      cfl     <= '0;
      acc     <= 1'b0;
    end else if (step) begin
      if (item.op == usbrx_pkg::OP_START) begin
        pos <= '0;
        cw  <= '0;
        acc <= 1'b0;
        cfl <= '0;
        if (!item.transfer_ok) begin
          framing <= 1'b0;
          bl      <= '0;
        end else begin
          bl      <= item.transfer_length;
          framing <= (item.transfer_length >= MIN_XFER);
        end
      end else if (!live) begin
        framing <= 1'b0;
      end else begin
        bl  <= bl_n;
        pos <= pos + 16'd1;
        if (head) begin
          cw <= cw_upd;
        end
        if ((pos == 16'd3) && !err && !item.queue_full) begin
          acc <= 1'b1;
          cfl <= len_m4[13:0];
        end
        // restart framing at the next prefix
        if (end_frame) begin
          pos     <= '0;
          cw      <= '0;
          acc     <= 1'b0;
          cfl     <= '0;
          framing <= (bl_n >= MIN_XFER);
        end
        if (bl_n == 16'd0) begin
          framing <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/usbrx_out_reg.sv
// ----------------------------------------------------------------------------
// usbrx_out_reg
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module usbrx_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  usbrx_pkg::result_t res,
  input  logic               m_ready,
  output logic               m_valid,
  output usbrx_pkg::result_t m_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= res_valid;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      m_res <= res;
    end
  end

endmodule

// File: sv/usb_bulk_rx_frame_splitter.sv
// ----------------------------------------------------------------------------
// usb_bulk_rx_frame_splitter
// Splits USB bulk-in transfers into Ethernet frame payload bytes and events.
//
//   channel  dir  handshake                    contents
//   s_axis   in   s_axis_tvalid/s_axis_tready  start of transfer or data byte
//   m_axis   out  m_axis_tvalid/m_axis_tready  payload byte or event
//   cfg      in   cfg_valid/cfg_ready          max_payload write
//
// One beat per cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register.
// A beat that gives no result leaves a bubble on the output.
// Reset is synchronous; it clears framing state and restores max_payload 1500.
// A stalled output holds; the input keeps flowing until both registers fill.
// ----------------------------------------------------------------------------
module usb_bulk_rx_frame_splitter #(
  parameter int PREFIX_BYTES  = 10,
  parameter int LENGTH_BITS   = 14,
  parameter int ERROR_BIT_POS = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] transfer_length, [16] transfer_ok, [24:17] data_byte,
  // [25] queue_full, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] first_of_frame, [22:9] payload_length, [23] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data
);

  usbrx_pkg::item_t   s_item;
  usbrx_pkg::item_t   item;
  usbrx_pkg::result_t res;
  usbrx_pkg::result_t m_res;
  logic               in_valid;
  logic               advance;
  logic               res_valid;

  assign s_item.op              = s_axis_tuser;
  assign s_item.transfer_length = s_axis_tdata[15:0];
  assign s_item.transfer_ok     = s_axis_tdata[16];
  assign s_item.data_byte       = s_axis_tdata[24:17];
  assign s_item.queue_full      = s_axis_tdata[25];

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_axis_tvalid || m_axis_tready);

  usbrx_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_item   (s_item),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  usbrx_parser #(
    .PREFIX_BYTES  (PREFIX_BYTES),
    .LENGTH_BITS   (LENGTH_BITS),
    .ERROR_BIT_POS (ERROR_BIT_POS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  usbrx_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .m_ready   (m_axis_tready),
    .m_valid   (m_axis_tvalid),
    .m_res     (m_res)
  );

  assign m_axis_tdata = {1'b0, m_res.payload_length, m_res.first_of_frame,
                         m_res.payload_byte};
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tlast = m_res.last_of_frame;

  // Input backpressure only comes from a full input register behind a stall.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  a_marks_on_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tlast || m_axis_tdata[8])) |->
      (m_axis_tuser == usbrx_pkg::KIND_PAYLOAD))
    else $error("frame mark on a non-payload result");

  a_fail_is_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == usbrx_pkg::KIND_FAIL)) |->
      (m_axis_tdata == 24'd0))
    else $error("transfer failure event carries data");

endmodule
